[rtl/core/line_connection_table_assert.svh]
// Assertion macros for the line connection table.
// Each macro expands to one labeled concurrent assertion on clk,
// disabled while rst_n is low.
`ifndef LINE_CONNECTION_TABLE_ASSERT_SVH
`define LINE_CONNECTION_TABLE_ASSERT_SVH

// Same-cycle implication.
`define LCT_ASSERT_NOW(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication.
`define LCT_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

[rtl/core/lct_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lct_pkg
// Shared types and constants for the line connection table.
// ----------------------------------------------------------------------------
package lct_pkg;

    localparam int NUM_W    = 16;
    localparam int STATUS_W = 4;

    // Reset value of the base dial number
    localparam logic [NUM_W-1:0] BASE_RESET = 16'd100;

    // Request kinds
    localparam logic KIND_CONNECT    = 1'b0;
    localparam logic KIND_DISCONNECT = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_CONNECTED   = 4'd0,
        ST_DECLINED    = 4'd1,
        ST_SRC_UNKNOWN = 4'd2,
        ST_SRC_BUSY    = 4'd3,
        ST_DST_UNKNOWN = 4'd4,
        ST_DST_BUSY    = 4'd5,
        ST_RELEASED    = 4'd6,
        ST_IDLE        = 4'd7,
        ST_NUM_UNKNOWN = 4'd8
    } status_t;

    typedef struct packed {
        status_t status;
        logic    released;
    } lct_result_t;

endpackage

[rtl/core/lct_lookup.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lct_lookup
// Map a dial number to a line index by subtracting the base number and
// range-checking the offset. No wrap at 16 bits.
// ----------------------------------------------------------------------------
module lct_lookup #(
    parameter int LINES = 16,
    parameter int IDX_W = 4
) (
    input  logic [lct_pkg::NUM_W-1:0] number,
    input  logic [lct_pkg::NUM_W-1:0] base,
    output logic                      hit,
    output logic [IDX_W-1:0]          idx
);
    import lct_pkg::*;

    logic [NUM_W:0] diff;

    // Offset from line zero; the top bit flags a number below the base
    assign diff = {1'b0, number} - {1'b0, base};
    assign hit  = !diff[NUM_W] && (diff[NUM_W-1:0] < NUM_W'(LINES));
    assign idx  = diff[IDX_W-1:0];

endmodule

[rtl/core/lct_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lct_table
// Busy bits and peer indexes of all lines, with the request decision logic.
// The result is combinational; the table updates when fire is high.
// ----------------------------------------------------------------------------
module lct_table #(
    parameter int LINES = 16,
    parameter int IDX_W = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  logic               kind,
    input  logic               src_ok,
    input  logic [IDX_W-1:0]   src_idx,
    input  logic               dst_ok,
    input  logic [IDX_W-1:0]   dst_idx,
    input  logic               force_release,
    input  logic               answered,
    output lct_pkg::lct_result_t result
);
    import lct_pkg::*;

    localparam int CNT_W = $clog2(LINES + 1);

    logic [LINES-1:0] busy_reg;
    logic [LINES-1:0] busy_next;
    logic [IDX_W-1:0] peer_reg  [LINES];
    logic [IDX_W-1:0] peer_next [LINES];

    logic             src_busy;
    logic [IDX_W-1:0] src_peer;
    logic             peer_ok;

    assign src_busy = busy_reg[src_idx];
    assign src_peer = peer_reg[src_idx];
    assign peer_ok  = CNT_W'(src_peer) < CNT_W'(LINES);

    // Decide the status and the table update for the held request
    always_comb
    begin
        busy_next       = busy_reg;
        peer_next       = peer_reg;
        result.status   = ST_IDLE;
        result.released = 1'b0;
        if (kind == KIND_DISCONNECT)
        begin
            if (!src_ok)
            begin
                result.status = ST_NUM_UNKNOWN;
            end
            else if (!src_busy)
            begin
                result.status = ST_IDLE;
            end
            else
            begin
                busy_next[src_idx] = 1'b0;
                peer_next[src_idx] = '0;
                if (peer_ok)
                begin
                    busy_next[src_peer] = 1'b0;
                    peer_next[src_peer] = '0;
                end
                result.status = ST_RELEASED;
            end
        end
        else
        begin
            if (!src_ok)
            begin
                result.status = ST_SRC_UNKNOWN;
            end
            else if (src_busy && !force_release)
            begin
                result.status = ST_SRC_BUSY;
            end
            else
            begin
                // Drop the source's earlier call first; it stays dropped
                if (src_busy)
                begin
                    busy_next[src_idx] = 1'b0;
                    peer_next[src_idx] = '0;
                    if (peer_ok)
                    begin
                        busy_next[src_peer] = 1'b0;
                        peer_next[src_peer] = '0;
                    end
                    result.released = 1'b1;
                end
                if (!dst_ok)
                begin
                    result.status = ST_DST_UNKNOWN;
                end
                else if (busy_next[dst_idx])
                begin
                    result.status = ST_DST_BUSY;
                end
                else if (!answered)
                begin
                    result.status = ST_DECLINED;
                end
                else
                begin
                    peer_next[src_idx] = dst_idx;
                    peer_next[dst_idx] = src_idx;
                    busy_next[src_idx] = 1'b1;
                    busy_next[dst_idx] = 1'b1;
                    result.status      = ST_CONNECTED;
                end
            end
        end
    end

    // Commit the update when the request advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
            for (int i = 0; i < LINES; i++)
            begin
                peer_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            busy_reg <= busy_next;
            peer_reg <= peer_next;
        end
    end

endmodule

[rtl/core/line_connection_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_connection_table
// Switch table for a small set of telephone lines: connect and disconnect
// requests, one status beat per request.
// ----------------------------------------------------------------------------
// Usage:
//   Request beats enter on in_valid/in_ready (kind, source_number,
//   dest_number, force_release, answered). Each gives exactly one result
//   beat on out_valid/out_ready (status_code, source_released).
//   The base dial number is written on cfg_valid/cfg_ready (always ready);
//   write it only while no request is in flight.
//   A request passes through an input register, one pass through number
//   lookup and the line table, and a result register. One request per cycle
//   is sustained while the receiver does not stall.
//   The line table updates as the request moves into the result register,
//   so back-to-back requests see each other's effect.
//   When the receiver stalls, the result holds in its register, the held
//   request waits in the input register, and in_ready drops after that.
//   Reset: all lines idle with zero peers, base number 100, no beats pending.
// ----------------------------------------------------------------------------
`include "line_connection_table_assert.svh"

module line_connection_table #(
    parameter int LINES = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lct_pkg::NUM_W-1:0]          base_number,
    // request channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               kind,
    input  logic [lct_pkg::NUM_W-1:0]          source_number,
    input  logic [lct_pkg::NUM_W-1:0]          dest_number,
    input  logic                               force_release,
    input  logic                               answered,
    // result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [lct_pkg::STATUS_W-1:0]       status_code,
    output logic                               source_released
);
    import lct_pkg::*;

    localparam int IDX_W = (LINES > 1) ? $clog2(LINES) : 1;

    logic [NUM_W-1:0]    base_reg;

    logic                stage_valid_reg;
    logic                kind_reg;
    logic [NUM_W-1:0]    source_number_reg;
    logic [NUM_W-1:0]    dest_number_reg;
    logic                force_release_reg;
    logic                answered_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_code_reg;
    logic                source_released_reg;

    logic                stage_fire;
    logic                src_ok;
    logic [IDX_W-1:0]    src_idx;
    logic                dst_ok;
    logic [IDX_W-1:0]    dst_idx;
    lct_result_t         result;

    // Handshake
    assign cfg_ready  = 1'b1;
    assign stage_fire = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !stage_valid_reg || stage_fire;

    // Base number register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            base_reg <= base_number;
        end
    end

    // Input register: hold the request beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (stage_fire)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg          <= kind;
            source_number_reg <= source_number;
            dest_number_reg   <= dest_number;
            force_release_reg <= force_release;
            answered_reg      <= answered;
        end
    end

    // Number lookup for source and destination
    lct_lookup #(
        .LINES (LINES),
        .IDX_W (IDX_W)
    ) u_src_lookup (
        .number (source_number_reg),
        .base   (base_reg),
        .hit    (src_ok),
        .idx    (src_idx)
    );

    lct_lookup #(
        .LINES (LINES),
        .IDX_W (IDX_W)
    ) u_dst_lookup (
        .number (dest_number_reg),
        .base   (base_reg),
        .hit    (dst_ok),
        .idx    (dst_idx)
    );

    // Line table and decision logic
    lct_table #(
        .LINES (LINES),
        .IDX_W (IDX_W)
    ) u_table (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (stage_fire),
        .kind          (kind_reg),
        .src_ok        (src_ok),
        .src_idx       (src_idx),
        .dst_ok        (dst_ok),
        .dst_idx       (dst_idx),
        .force_release (force_release_reg),
        .answered      (answered_reg),
        .result        (result)
    );

    // Result register: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_fire)
        begin
            status_code_reg     <= result.status;
            source_released_reg <= result.released;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status_code     = status_code_reg;
    assign source_released = source_released_reg;

    // Checks
    `LCT_ASSERT_NEXT(a_fire_gives_result, stage_fire, out_valid_reg,
        "advanced request gave no result beat")
    `LCT_ASSERT_NOW(a_no_overwrite, out_valid_reg && !out_ready, !stage_fire,
        "waiting result overwritten")
    `LCT_ASSERT_NEXT(a_disconnect_no_release, stage_fire && kind_reg == KIND_DISCONNECT,
        !source_released, "disconnect flagged a source release")
    `LCT_ASSERT_NOW(a_status_range, out_valid_reg,
        status_code <= STATUS_W'(ST_NUM_UNKNOWN), "status code out of range")

endmodule

[tb/sv/tb_line_connection_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_connection_table
// Self-checking bench for the line connection table. Directed calls walk
// every status path (busy source with and without forced release, unknown
// numbers, self joins, idle and unknown disconnects, the extreme base
// numbers), then random traffic runs under several base numbers. Both
// channels idle at random. A local copy of the line table predicts every
// status beat, and a checker compares each beat in order.
// ----------------------------------------------------------------------------
module tb_line_connection_table;
    import lct_pkg::*;

    localparam int LINES       = 16;
    localparam int LINE_W      = $clog2(LINES);
    localparam int CLK_HALF    = 4;
    localparam int RESET_LEN   = 7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 4;

    typedef struct packed {
        logic             kind;
        logic [NUM_W-1:0] source;
        logic [NUM_W-1:0] dest;
        logic             force_rel;
        logic             answered;
    } call_req_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [NUM_W-1:0]    base_number;
    logic                in_valid;
    logic                in_ready;
    logic                kind;
    logic [NUM_W-1:0]    source_number;
    logic [NUM_W-1:0]    dest_number;
    logic                force_release;
    logic                answered;
    logic                out_valid;
    logic                out_ready;
    logic [STATUS_W-1:0] status_code;
    logic                source_released;

    // Local copy of the switch table
    logic [NUM_W-1:0]  sw_base;
    logic              sw_busy [LINES];
    logic [LINE_W-1:0] sw_peer [LINES];

    lct_result_t       pending_status_q [$];
    int unsigned       error_count = 0;

    // Idle pattern state for each side
    int unsigned       in_run_left  = 0;
    bit                in_calm      = 1'b0;
    int unsigned       out_run_left = 0;
    bit                out_calm     = 1'b0;

    line_connection_table #(
        .LINES(LINES)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .base_number    (base_number),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .source_number  (source_number),
        .dest_number    (dest_number),
        .force_release  (force_release),
        .answered       (answered),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status_code    (status_code),
        .source_released(source_released)
    );

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Map a dial number to a line; no wrap past 16 bits
    function automatic bit dial_to_line(input logic [NUM_W-1:0] num,
                                        output logic [LINE_W-1:0] line);
        logic [NUM_W:0] offset;
        line = '0;
        if (num < sw_base)
            return 1'b0;
        offset = {1'b0, num} - {1'b0, sw_base};
        if (offset >= LINES)
            return 1'b0;
        line = offset[LINE_W-1:0];
        return 1'b1;
    endfunction

    // Drop a line and its peer back to idle
    function automatic void free_line(input logic [LINE_W-1:0] line);
        logic [LINE_W-1:0] mate;
        mate          = sw_peer[line];
        sw_busy[line] = 1'b0;
        sw_peer[line] = '0;
        sw_busy[mate] = 1'b0;
        sw_peer[mate] = '0;
    endfunction

    function automatic lct_result_t switch_call(input call_req_t req);
        lct_result_t       res;
        logic [LINE_W-1:0] src;
        logic [LINE_W-1:0] dst;
        res.status   = ST_CONNECTED;
        res.released = 1'b0;
        if (req.kind == KIND_DISCONNECT)
        begin
            if (!dial_to_line(req.source, src))
                res.status = ST_NUM_UNKNOWN;
            else if (!sw_busy[src])
                res.status = ST_IDLE;
            else
            begin
                free_line(src);
                res.status = ST_RELEASED;
            end
        end
        else if (!dial_to_line(req.source, src))
            res.status = ST_SRC_UNKNOWN;
        else if (sw_busy[src] && !req.force_rel)
            res.status = ST_SRC_BUSY;
        else
        begin
            // A forced release stands even if the call then fails
            if (sw_busy[src])
            begin
                free_line(src);
                res.released = 1'b1;
            end
            if (!dial_to_line(req.dest, dst))
                res.status = ST_DST_UNKNOWN;
            else if (sw_busy[dst])
                res.status = ST_DST_BUSY;
            else if (!req.answered)
                res.status = ST_DECLINED;
            else
            begin
                sw_peer[src] = dst;
                sw_peer[dst] = src;
                sw_busy[src] = 1'b1;
                sw_busy[dst] = 1'b1;
                res.status   = ST_CONNECTED;
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // Draw a wait in cycles; alternate calm stretches with idle-heavy ones
    function automatic int unsigned draw_wait(inout int unsigned run_left,
                                              inout bit calm);
        if (run_left == 0)
        begin
            run_left = $urandom_range(8, 40);
            calm     = ($urandom_range(0, 3) == 0);
        end
        run_left--;
        if (calm)
            return 0;
        case ($urandom_range(0, 3))
            0:       return 0;
            1, 2:    return $urandom_range(0, 3);
            default: return $urandom_range(0, 15);
        endcase
    endfunction

    // Send one request beat and queue its predicted status
    task automatic send_call(input logic k, input logic [NUM_W-1:0] src,
                             input logic [NUM_W-1:0] dst, input logic frc,
                             input logic ans);
        call_req_t   req;
        int unsigned gap;
        req.kind      = k;
        req.source    = src;
        req.dest      = dst;
        req.force_rel = frc;
        req.answered  = ans;
        gap = draw_wait(in_run_left, in_calm);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        kind          <= k;
        source_number <= src;
        dest_number   <= dst;
        force_release <= frc;
        answered      <= ans;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_status_q.push_back(switch_call(req));
    endtask

    // Stop sending and wait until every status beat is back
    task automatic drain_calls();
        in_valid <= 1'b0;
        while (pending_status_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Write the base number; call only while the table is idle
    task automatic write_base(input logic [NUM_W-1:0] value);
        cfg_valid   <= 1'b1;
        base_number <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sw_base = value;
        cfg_valid <= 1'b0;
    endtask

    // Mostly reachable numbers, some just outside, some anywhere
    function automatic logic [NUM_W-1:0] pick_number();
        case ($urandom_range(0, 9))
            0:       return NUM_W'($urandom_range(0, 16'hFFFF));
            1:       return NUM_W'(sw_base + LINES + $urandom_range(0, 2));
            2:       return NUM_W'(sw_base - $urandom_range(1, 2));
            default: return NUM_W'(sw_base + $urandom_range(0, LINES - 1));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_basic_connect();
        send_call(KIND_CONNECT, 16'd100, 16'd101, 1'b0, 1'b1);
        send_call(KIND_CONNECT, 16'd102, 16'd103, 1'b0, 1'b0);
        send_call(KIND_CONNECT, 16'd102, 16'd101, 1'b0, 1'b1);
    endtask

    task automatic test_busy_source();
        send_call(KIND_CONNECT, 16'd100, 16'd104, 1'b0, 1'b1);
        // Forced release stays even though the callee declines
        send_call(KIND_CONNECT, 16'd100, 16'd104, 1'b1, 1'b0);
        send_call(KIND_CONNECT, 16'd102, 16'd103, 1'b1, 1'b1);
        // Release frees the old peer, which is the new destination
        send_call(KIND_CONNECT, 16'd102, 16'd103, 1'b1, 1'b1);
        send_call(KIND_CONNECT, 16'd102, 16'hFFFF, 1'b1, 1'b1);
    endtask

    task automatic test_number_range();
        send_call(KIND_CONNECT, 16'd99, 16'd101, 1'b0, 1'b1);
        send_call(KIND_CONNECT, 16'd116, 16'd101, 1'b0, 1'b1);
        send_call(KIND_CONNECT, 16'd115, 16'd116, 1'b0, 1'b1);
        send_call(KIND_CONNECT, 16'd100, 16'd99, 1'b0, 1'b1);
    endtask

    task automatic test_self_connect();
        send_call(KIND_CONNECT, 16'd115, 16'd115, 1'b0, 1'b1);
        send_call(KIND_CONNECT, 16'd108, 16'd115, 1'b0, 1'b1);
        send_call(KIND_DISCONNECT, 16'd115, 16'd0, 1'b0, 1'b0);
    endtask

    task automatic test_disconnect();
        send_call(KIND_CONNECT, 16'd105, 16'd106, 1'b0, 1'b1);
        send_call(KIND_DISCONNECT, 16'd106, 16'hFFFF, 1'b1, 1'b1);
        send_call(KIND_DISCONNECT, 16'd105, 16'd105, 1'b0, 1'b1);
        send_call(KIND_DISCONNECT, 16'd0, 16'd100, 1'b1, 1'b0);
        send_call(KIND_DISCONNECT, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    endtask

    task automatic test_base_extremes();
        drain_calls();
        write_base(16'd0);
        send_call(KIND_CONNECT, 16'd0, 16'd15, 1'b1, 1'b1);
        send_call(KIND_DISCONNECT, 16'd15, 16'd0, 1'b0, 1'b0);
        drain_calls();
        // Only line zero is reachable at the top of the number space
        write_base(16'hFFFF);
        send_call(KIND_CONNECT, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
        send_call(KIND_CONNECT, 16'hFFFF, 16'h0000, 1'b1, 1'b1);
        send_call(KIND_DISCONNECT, 16'hFFFF, 16'h0000, 1'b0, 1'b0);
        drain_calls();
    endtask

    task automatic test_random_traffic(input logic [NUM_W-1:0] base,
                                       input int unsigned count);
        logic k;
        write_base(base);
        repeat (count)
        begin
            k = ($urandom_range(0, 9) < 4) ? KIND_DISCONNECT : KIND_CONNECT;
            send_call(k, pick_number(), pick_number(), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 3) != 0);
        end
        drain_calls();
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Stall the result channel at random
    initial
    begin : result_sink
        int unsigned stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_wait(out_run_left, out_calm);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Compare each status beat with the oldest prediction
    always @(posedge clk)
    begin : result_check
        lct_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_status_q.size() == 0)
            begin
                $error("unexpected status beat: status_code %0d", status_code);
                error_count++;
            end
            else
            begin
                want = pending_status_q.pop_front();
                if (status_code !== want.status)
                begin
                    $error("status_code: expected %0d, got %0d",
                           want.status, status_code);
                    error_count++;
                end
                if (source_released !== want.released)
                begin
                    $error("source_released: expected %0b, got %0b",
                           want.released, source_released);
                    error_count++;
                end
            end
        end
    end

    // Abort a hung run
    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("** line_connection_table: FAILED **");
        $finish;
    end

    initial
    begin : run_tests
        int i;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        base_number   = BASE_RESET;
        in_valid      = 1'b0;
        kind          = KIND_CONNECT;
        source_number = '0;
        dest_number   = '0;
        force_release = 1'b0;
        answered      = 1'b0;
        sw_base       = BASE_RESET;
        for (i = 0; i < LINES; i++)
        begin
            sw_busy[i] = 1'b0;
            sw_peer[i] = '0;
        end
        repeat (RESET_LEN) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed calls run on the reset base number, but the base extremes test writes its own
        test_basic_connect();
        test_busy_source();
        test_number_range();
        test_self_connect();
        test_disconnect();
        test_base_extremes();

        test_random_traffic(16'd100, 400);
        test_random_traffic(16'd0, 300);
        test_random_traffic(16'hFFF8, 250);
        test_random_traffic(16'hFFFF, 100);
        test_random_traffic(NUM_W'($urandom_range(0, 16'hFFFF)), 350);

        if (error_count == 0)
            $display("** line_connection_table: PASSED **");
        else
            $display("** line_connection_table: FAILED **");
        $finish;
    end

endmodule
